>>> hw/rtl/pooled_indexed_linked_list_defines.svh
// Assertion macros for the pooled indexed linked list.
// Included by the top level; needs no package.
`ifndef POOLED_INDEXED_LINKED_LIST_DEFINES_SVH
`define POOLED_INDEXED_LINKED_LIST_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PIL_ASSERT_NOW(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define PIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/pil_pkg.sv
// Shared types and constants for the pooled indexed linked list.
// Used by pil_store and pooled_indexed_linked_list; depends on nothing.
package pil_pkg;

  localparam int MODE_W   = 2;
  localparam int POS_W    = 6;
  localparam int SIZE_W   = 7;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIZE   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_INS,
    S_DEL,
    S_DONE
  } state_e;

  // Write enables of the three slot stores.
  typedef struct packed {
    logic link;
    logic busy;
    logic word;
  } wen_t;

endpackage

>>> hw/rtl/pil_store.sv
// Slot pool storage: next links, busy flags and data words, each with one
// write port and one registered read port. Depends on pil_pkg.
module pil_store #(
  parameter int POOL_SIZE  = 64,
  parameter int WORD_WIDTH = 32,
  localparam int PW = $clog2(POOL_SIZE)
) (
  input  logic                  clk_i,
  input  pil_pkg::wen_t         wen_i,
  input  logic [PW-1:0]         link_waddr_i,
  input  logic [PW-1:0]         link_wdata_i,
  input  logic [PW-1:0]         link_raddr_i,
  input  logic [PW-1:0]         slot_waddr_i,
  input  logic                  busy_wdata_i,
  input  logic [WORD_WIDTH-1:0] word_wdata_i,
  input  logic [PW-1:0]         busy_raddr_i,
  output logic [PW-1:0]         link_rdata_o,
  output logic                  busy_rdata_o,
  output logic [WORD_WIDTH-1:0] word_rdata_o
);

  logic [PW-1:0]         link_mem [POOL_SIZE];
  logic                  busy_mem [POOL_SIZE];
  logic [WORD_WIDTH-1:0] word_mem [POOL_SIZE];

  always_ff @(posedge clk_i) begin
    if (wen_i.link) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    link_rdata_o <= link_mem[link_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wen_i.busy) begin
      busy_mem[slot_waddr_i] <= busy_wdata_i;
    end
    busy_rdata_o <= busy_mem[busy_raddr_i];
  end

  // The data word is read at the same slot as the link.
  always_ff @(posedge clk_i) begin
    if (wen_i.word) begin
      word_mem[slot_waddr_i] <= word_wdata_i;
    end
    word_rdata_o <= word_mem[link_raddr_i];
  end

endmodule

>>> hw/rtl/pooled_indexed_linked_list.sv
// Pooled indexed linked list: an ordered list of words threaded through POOL_SIZE slots held
// in memories with one write and one read port (pil_store), driven by pil_pkg types and a
// small sequencer. After reset the block clears its busy flags slot by slot and holds
// in_stall_o high. Each operation then runs alone: a size query or an error result goes
// straight to the done state and then to the output register; a delete at position P walks
// the list with one link-memory read per hop; an insert first scans the busy flags for the
// lowest free slot, then walks P - 1 hops and links the slot in. The result sits in an
// output register, so the next beat is taken while it waits.
`include "pooled_indexed_linked_list_defines.svh"

module pooled_indexed_linked_list #(
  parameter int POOL_SIZE  = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pil_pkg::MODE_W-1:0]     mode_i,
  input  logic [pil_pkg::POS_W-1:0]      position_i,
  input  logic [WORD_WIDTH-1:0]          data_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [WORD_WIDTH-1:0]          data_out_o,
  output logic [pil_pkg::SIZE_W-1:0]     list_size_o,
  output logic [pil_pkg::STATUS_W-1:0]   status_o
);

  localparam int PW   = $clog2(POOL_SIZE);
  localparam int CW   = $clog2(POOL_SIZE + 1);
  localparam int CMPW = (CW > pil_pkg::POS_W) ? CW : pil_pkg::POS_W;
  localparam logic [PW-1:0] LAST_SLOT = PW'(POOL_SIZE - 1);

  pil_pkg::state_e state_q, state_d;

  logic [PW-1:0]                   idx_q, idx_d;
  logic [PW-1:0]                   chk_q, chk_d;
  logic                            pend_q, pend_d;
  logic [PW-1:0]                   cur_q, cur_d;
  logic [PW-1:0]                   slot_q, slot_d;
  logic [PW-1:0]                   head_q, head_d;
  logic [pil_pkg::POS_W-1:0]       remain_q, remain_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [pil_pkg::MODE_W-1:0]      mode_q, mode_d;
  logic [pil_pkg::POS_W-1:0]       pos_q, pos_d;
  logic [WORD_WIDTH-1:0]           word_q, word_d;
  logic [WORD_WIDTH-1:0]           dout_q, dout_d;
  logic [pil_pkg::STATUS_W-1:0]    st_q, st_d;
  logic                            out_valid_q, out_valid_d;
  logic [WORD_WIDTH-1:0]           out_data_q, out_data_d;
  logic [pil_pkg::SIZE_W-1:0]      out_size_q, out_size_d;
  logic [pil_pkg::STATUS_W-1:0]    out_status_q, out_status_d;

  pil_pkg::wen_t                   wen;
  logic [PW-1:0]                   link_waddr, link_wdata, link_raddr;
  logic [PW-1:0]                   slot_waddr, busy_raddr;
  logic                            busy_wdata;
  logic [WORD_WIDTH-1:0]           word_wdata;
  logic [PW-1:0]                   link_rdata;
  logic                            busy_rdata;
  logic [WORD_WIDTH-1:0]           word_rdata;

  logic [CMPW-1:0]                 pos_ext, cnt_ext;

  assign pos_ext = CMPW'(position_i);
  assign cnt_ext = CMPW'(count_q);

  pil_store #(
    .POOL_SIZE  (POOL_SIZE),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_store (
    .clk_i        (clk_i),
    .wen_i        (wen),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .link_raddr_i (link_raddr),
    .slot_waddr_i (slot_waddr),
    .busy_wdata_i (busy_wdata),
    .word_wdata_i (word_wdata),
    .busy_raddr_i (busy_raddr),
    .link_rdata_o (link_rdata),
    .busy_rdata_o (busy_rdata),
    .word_rdata_o (word_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pil_pkg::S_CLEAR;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q        <= chk_d;
    cur_q        <= cur_d;
    slot_q       <= slot_d;
    head_q       <= head_d;
    remain_q     <= remain_d;
    mode_q       <= mode_d;
    pos_q        <= pos_d;
    word_q       <= word_d;
    dout_q       <= dout_d;
    st_q         <= st_d;
    out_data_q   <= out_data_d;
    out_size_q   <= out_size_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    chk_d        = chk_q;
    pend_d       = pend_q;
    cur_d        = cur_q;
    slot_d       = slot_q;
    head_d       = head_q;
    remain_d     = remain_q;
    count_d      = count_q;
    mode_d       = mode_q;
    pos_d        = pos_q;
    word_d       = word_q;
    dout_d       = dout_q;
    st_d         = st_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_size_d   = out_size_q;
    out_status_d = out_status_q;

    wen          = '0;
    link_waddr   = cur_q;
    link_wdata   = slot_q;
    link_raddr   = cur_q;
    slot_waddr   = slot_q;
    busy_wdata   = 1'b0;
    word_wdata   = word_q;
    busy_raddr   = idx_q;
    in_stall_o   = 1'b1;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pil_pkg::S_CLEAR: begin
        wen.busy   = 1'b1;
        slot_waddr = idx_q;
        busy_wdata = 1'b0;
        if (idx_q == LAST_SLOT) begin
          idx_d   = '0;
          state_d = pil_pkg::S_IDLE;
        end else begin
          idx_d = idx_q + PW'(1);
        end
      end

      pil_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          mode_d  = mode_i;
          pos_d   = position_i;
          word_d  = data_in_i;
          dout_d  = '0;
          st_d    = pil_pkg::STATUS_OK;
          pend_d  = 1'b0;
          state_d = pil_pkg::S_DONE;
          case (mode_i)
            pil_pkg::MODE_INSERT: begin
              // The full check takes precedence over the position check.
              if (count_q == CW'(POOL_SIZE)) begin
                st_d = pil_pkg::STATUS_FULL;
              end else if (pos_ext > cnt_ext) begin
                st_d = pil_pkg::STATUS_RANGE;
              end else begin
                idx_d   = '0;
                state_d = pil_pkg::S_SCAN;
              end
            end
            pil_pkg::MODE_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                st_d = pil_pkg::STATUS_RANGE;
              end else begin
                link_raddr = head_q;
                cur_d      = head_q;
                slot_d     = head_q;
                if (position_i == '0) begin
                  state_d = pil_pkg::S_DEL;
                end else begin
                  remain_d = position_i - pil_pkg::POS_W'(1);
                  state_d  = pil_pkg::S_WALK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      pil_pkg::S_SCAN: begin
        // One busy flag is read per cycle; chk_q names the slot whose flag is
        // on the read port now.
        busy_raddr = idx_q;
        pend_d     = 1'b1;
        chk_d      = idx_q;
        if (idx_q != LAST_SLOT) begin
          idx_d = idx_q + PW'(1);
        end
        if (pend_q && !busy_rdata) begin
          slot_d = chk_q;
          pend_d = 1'b0;
          if (pos_q == '0) begin
            state_d = pil_pkg::S_INS;
          end else begin
            link_raddr = head_q;
            cur_d      = head_q;
            remain_d   = pos_q - pil_pkg::POS_W'(1);
            state_d    = pil_pkg::S_WALK;
          end
        end
      end

      pil_pkg::S_WALK: begin
        // cur_q is the slot just read; the read data is its next link.
        if (remain_q != '0) begin
          link_raddr = link_rdata;
          cur_d      = link_rdata;
          remain_d   = remain_q - pil_pkg::POS_W'(1);
        end else if (mode_q == pil_pkg::MODE_INSERT) begin
          wen.link   = 1'b1;
          link_waddr = slot_q;
          link_wdata = link_rdata;
          state_d    = pil_pkg::S_INS;
        end else begin
          slot_d     = link_rdata;
          link_raddr = link_rdata;
          state_d    = pil_pkg::S_DEL;
        end
      end

      pil_pkg::S_INS: begin
        wen.busy   = 1'b1;
        wen.word   = 1'b1;
        wen.link   = 1'b1;
        slot_waddr = slot_q;
        busy_wdata = 1'b1;
        word_wdata = word_q;
        if (pos_q == '0) begin
          link_waddr = slot_q;
          link_wdata = head_q;
          head_d     = slot_q;
        end else begin
          link_waddr = cur_q;
          link_wdata = slot_q;
        end
        count_d = count_q + CW'(1);
        state_d = pil_pkg::S_DONE;
      end

      pil_pkg::S_DEL: begin
        // The link and word of the removed slot are on the read ports.
        wen.busy   = 1'b1;
        slot_waddr = slot_q;
        busy_wdata = 1'b0;
        dout_d     = word_rdata;
        if (pos_q == '0) begin
          head_d = link_rdata;
        end else begin
          wen.link   = 1'b1;
          link_waddr = cur_q;
          link_wdata = link_rdata;
        end
        count_d = count_q - CW'(1);
        state_d = pil_pkg::S_DONE;
      end

      pil_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_data_d   = dout_q;
          out_size_d   = pil_pkg::SIZE_W'(count_q);
          out_status_d = st_q;
          state_d      = pil_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pil_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign list_size_o = out_size_q;
  assign status_o    = out_status_q;

  `PIL_ASSERT_NOW(a_count_bound, clk_i, rst_ni, count_q <= CW'(POOL_SIZE), "word count exceeds pool")
  `PIL_ASSERT_NOW(a_ins_room, clk_i, rst_ni, state_q != pil_pkg::S_INS || count_q != CW'(POOL_SIZE), "insert on full pool")
  `PIL_ASSERT_NOW(a_del_nonempty, clk_i, rst_ni, state_q != pil_pkg::S_DEL || count_q != '0, "delete on empty list")
  `PIL_ASSERT_NEXT(a_count_hold, clk_i, rst_ni, state_q == pil_pkg::S_IDLE || state_q == pil_pkg::S_SCAN || state_q == pil_pkg::S_DONE, $stable(count_q), "count changed outside link update")

endmodule
